/* hdl/mqtt_rd_pkg.sv */
`default_nettype none

package mqtt_rd_pkg;

  // Stream and configuration widths
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_USER_W = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 28;

  // Topic bytes at index TOPIC_BUF - 1 and above are dropped
  localparam int TOPIC_BUF = 64;
  localparam logic [27:0] TOPIC_KEEP = 28'(TOPIC_BUF - 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BODY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'd1;

  localparam logic [27:0] MAX_BODY_RST = 28'd1024;
  localparam logic [15:0] TIMEOUT_RST  = 16'd5000;

  // Item kinds on the slave-side tuser
  localparam logic [1:0] MODE_BYTE    = 2'd0;
  localparam logic [1:0] MODE_TICK    = 2'd1;
  localparam logic [1:0] MODE_CLOSED  = 2'd2;
  localparam logic [1:0] MODE_CONNECT = 2'd3;

  // Result events
  localparam logic [3:0] EV_NONE     = 4'd0;
  localparam logic [3:0] EV_HEADER   = 4'd1;
  localparam logic [3:0] EV_LEN      = 4'd2;
  localparam logic [3:0] EV_BODY     = 4'd3;
  localparam logic [3:0] EV_DISCARD  = 4'd4;
  localparam logic [3:0] EV_TIMEOUT  = 4'd5;
  localparam logic [3:0] EV_CLOSED   = 4'd6;
  localparam logic [3:0] EV_BAD_LEN  = 4'd7;
  localparam logic [3:0] EV_CONNECT  = 4'd8;

  // Body byte sections
  localparam logic [2:0] SEC_NONE      = 3'd0;
  localparam logic [2:0] SEC_TOPIC_LEN = 3'd1;
  localparam logic [2:0] SEC_TOPIC     = 3'd2;
  localparam logic [2:0] SEC_TOPIC_DRP = 3'd3;
  localparam logic [2:0] SEC_PKT_ID    = 3'd4;
  localparam logic [2:0] SEC_PAYLOAD   = 3'd5;
  localparam logic [2:0] SEC_OTHER     = 3'd6;

  // Link states
  localparam logic [1:0] LINK_DOWN       = 2'd0;
  localparam logic [1:0] LINK_CONNECTING = 2'd1;
  localparam logic [1:0] LINK_UP         = 2'd2;

  // Receive phases
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_LENGTH  = 2'd1;
  localparam logic [1:0] PH_BODY    = 2'd2;
  localparam logic [1:0] PH_DISCARD = 2'd3;

  // Packet types (upper nibble of the fixed header)
  localparam logic [3:0] PT_CONNACK = 4'h2;
  localparam logic [3:0] PT_PUBLISH = 4'h3;
  localparam logic [3:0] PT_PUBACK  = 4'h4;

  // One result item
  typedef struct packed {
    logic [3:0]  event_res;
    logic [7:0]  data_byte;
    logic [2:0]  section;
    logic [3:0]  packet_type;
    logic [3:0]  header_flags;
    logic [27:0] body_length;
    logic        packet_done;
    logic [1:0]  link_status;
    logic        publish_ok;
    logic [15:0] msg_id;
    logic        send_puback;
    logic        ack_matched;
  } res_t;

endpackage

`default_nettype wire

/* hdl/mqtt_receive_deframer.sv */
`default_nettype none
// MQTT 3.1.1 receive deframer.
// Slave stream: one item per transfer. tuser carries the item kind (received
// byte, millisecond tick, peer closed, connect started); tdata carries the
// received byte and the packet id currently awaiting a PUBACK.
// Master stream: exactly one result per input item. tuser carries the event
// code and the body section of the byte; tlast marks the item that completes
// or finishes discarding a packet; tdata carries the byte echo, header
// nibbles, decoded remaining length, link status and the end-of-packet
// PUBLISH / PUBACK report.
// Configuration channel: index 0 sets the largest accepted body, index 1 the
// tick limit for finishing a packet. Write only while the block is idle.
// The result of an item accepted at an edge is valid after that edge.
// Throughput is one item per cycle, set by the single output register;
// the next item is taken while the current result is being taken. When
// the receiver stalls, the result is held and tready drops until it is
// taken.
// Reset (rst, synchronous) leaves the link disconnected, the receiver idle,
// the output empty and both configuration registers at their defaults.
module mqtt_receive_deframer (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // tdata: rx_byte [7:0], pending_ack_id [23:8]
  input  wire logic [mqtt_rd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser: mode [1:0]
  input  wire logic [mqtt_rd_pkg::IN_USER_W-1:0]   s_axis_tuser,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // tdata: data_byte [7:0], packet_type [11:8], header_flags [15:12],
  // body_length [43:16], link_status [45:44], publish_ok [46],
  // msg_id [62:47], send_puback [63], ack_matched [64], zero [71:65]
  output logic [mqtt_rd_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // tuser: event_res [3:0], section [6:4]
  output logic [mqtt_rd_pkg::OUT_USER_W-1:0]       m_axis_tuser,
  output logic                                     m_axis_tlast,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [mqtt_rd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mqtt_rd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mqtt_rd_pkg::*;

  // Configuration registers
  logic [27:0] max_body_len;
  logic [15:0] timeout_ms;

  // Receiver state
  logic [1:0]  link_state, link_pre, link_next;
  logic [1:0]  phase, phase_next;
  logic [7:0]  fixed_header, fixed_header_next;
  logic [27:0] rem_len, rem_len_next;
  logic [2:0]  len_count, len_count_next;
  logic [27:0] body_pos, body_pos_next;
  logic [15:0] elapsed, elapsed_next;
  logic [15:0] topic_size, topic_size_next;
  logic [15:0] acc_id, acc_id_next;
  logic [7:0]  ret_code, ret_code_next;

  // Output register
  res_t        res, res_next;
  logic        out_valid;

  // Item fields and helpers
  logic [1:0]  mode;
  logic [7:0]  rx_byte;
  logic [15:0] pending_ack_id;
  logic        accept;
  logic [15:0] elapsed_inc;
  logic [27:0] len_addend;
  logic [27:0] len_sum;
  logic [27:0] pos_inc;
  logic [27:0] pos_m2;
  logic [27:0] tl_ext;
  logic [27:0] pos_past_topic;
  logic [1:0]  qos;
  logic [3:0]  ptype;
  logic        fin;
  logic [3:0]  ev;
  logic [7:0]  data_b;
  logic [2:0]  sec;
  logic        done;

  // End-of-packet report
  logic [16:0] need;
  logic [17:0] need_id;
  logic        rl_ge2;
  logic        pub_ok;
  logic        pub_ok_q;
  logic [15:0] pid;
  logic        puback;
  logic        match;

  assign mode           = s_axis_tuser[1:0];
  assign rx_byte        = s_axis_tdata[7:0];
  assign pending_ack_id = s_axis_tdata[23:8];

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // Saturating tick count
  assign elapsed_inc = (elapsed == 16'hFFFF) ? elapsed : elapsed + 16'd1;

  // Base-128 length digit placed by its position
  always_comb begin
    unique case (len_count[1:0])
      2'd0: len_addend = {21'd0, rx_byte[6:0]};
      2'd1: len_addend = {14'd0, rx_byte[6:0], 7'd0};
      2'd2: len_addend = {7'd0, rx_byte[6:0], 14'd0};
      default: len_addend = {rx_byte[6:0], 21'd0};
    endcase
  end
  assign len_sum = rem_len + len_addend;

  assign pos_inc        = body_pos + 28'd1;
  assign pos_m2         = body_pos - 28'd2;
  assign tl_ext         = {12'd0, topic_size};
  assign pos_past_topic = pos_m2 - tl_ext;
  assign qos            = fixed_header[2:1];
  assign ptype          = fixed_header[7:4];

  // Per-item state update
  always_comb begin
    link_pre          = link_state;
    phase_next        = phase;
    fixed_header_next = fixed_header;
    rem_len_next      = rem_len;
    len_count_next    = len_count;
    body_pos_next     = body_pos;
    elapsed_next      = elapsed;
    topic_size_next   = topic_size;
    acc_id_next       = acc_id;
    ret_code_next     = ret_code;
    fin               = 1'b0;
    ev                = EV_NONE;
    data_b            = 8'd0;
    sec               = SEC_NONE;
    done              = 1'b0;

    if (mode == MODE_CONNECT) begin
      link_pre   = LINK_CONNECTING;
      phase_next = PH_IDLE;
      ev         = EV_CONNECT;
    end else if (link_state == LINK_DOWN) begin
      ev = EV_NONE;
    end else if (mode == MODE_CLOSED) begin
      link_pre   = LINK_DOWN;
      phase_next = PH_IDLE;
      ev         = EV_CLOSED;
    end else if (mode == MODE_TICK) begin
      if (phase != PH_IDLE) begin
        elapsed_next = elapsed_inc;
        if (elapsed_inc >= timeout_ms) begin
          link_pre   = LINK_DOWN;
          phase_next = PH_IDLE;
          ev         = EV_TIMEOUT;
        end
      end
    end else if (phase != PH_IDLE && elapsed >= timeout_ms) begin
      // byte arriving after the deadline is lost
      link_pre   = LINK_DOWN;
      phase_next = PH_IDLE;
      ev         = EV_TIMEOUT;
    end else if (phase == PH_IDLE) begin
      fixed_header_next = rx_byte;
      rem_len_next      = '0;
      len_count_next    = '0;
      body_pos_next     = '0;
      elapsed_next      = '0;
      topic_size_next   = '0;
      acc_id_next       = '0;
      ret_code_next     = '0;
      phase_next        = PH_LENGTH;
      ev                = EV_HEADER;
    end else if (phase == PH_LENGTH) begin
      if (len_count >= 3'd4) begin
        link_pre   = LINK_DOWN;
        phase_next = PH_IDLE;
        ev         = EV_BAD_LEN;
      end else begin
        rem_len_next   = len_sum;
        len_count_next = len_count + 3'd1;
        ev             = EV_LEN;
        if (!rx_byte[7]) begin
          body_pos_next = '0;
          if (len_sum == 28'd0) begin
            phase_next = PH_IDLE;
            fin        = 1'b1;
            done       = 1'b1;
          end else if (len_sum <= max_body_len) begin
            phase_next = PH_BODY;
          end else begin
            phase_next = PH_DISCARD;
          end
        end
      end
    end else begin
      data_b = rx_byte;
      if (phase == PH_BODY) begin
        ev = EV_BODY;
        // section tagging
        if (ptype == PT_PUBLISH) begin
          if (body_pos < 28'd2) begin
            topic_size_next = {topic_size[7:0], rx_byte};
            sec             = SEC_TOPIC_LEN;
          end else if (pos_m2 < tl_ext) begin
            sec = (pos_m2 < TOPIC_KEEP) ? SEC_TOPIC : SEC_TOPIC_DRP;
          end else if (qos != 2'd0 && pos_past_topic < 28'd2) begin
            acc_id_next = {acc_id[7:0], rx_byte};
            sec         = SEC_PKT_ID;
          end else begin
            sec = SEC_PAYLOAD;
          end
        end else if (ptype == PT_PUBACK && body_pos < 28'd2) begin
          acc_id_next = {acc_id[7:0], rx_byte};
          sec         = SEC_PKT_ID;
        end else begin
          if (ptype == PT_CONNACK && body_pos == 28'd1) begin
            ret_code_next = rx_byte;
          end
          sec = SEC_OTHER;
        end
      end else begin
        ev = EV_DISCARD;
      end
      body_pos_next = pos_inc;
      if (pos_inc >= rem_len) begin
        phase_next = PH_IDLE;
        fin        = (phase == PH_BODY);
        done       = 1'b1;
      end
    end
  end

  // End-of-packet report on the updated packet state
  assign rl_ge2   = rem_len_next >= 28'd2;
  assign need     = 17'd2 + {1'b0, topic_size_next};
  assign need_id  = {1'b0, need} + 18'd2;
  assign pub_ok_q = rl_ge2 && ({11'd0, need} <= rem_len_next);
  assign pub_ok   = pub_ok_q &&
                    (fixed_header_next[2:1] == 2'd0 || {10'd0, need_id} <= rem_len_next);

  always_comb begin
    link_next = link_pre;
    pid       = '0;
    puback    = 1'b0;
    match     = 1'b0;
    if (fin) begin
      unique case (fixed_header_next[7:4])
        PT_CONNACK: begin
          link_next = (rl_ge2 && ret_code_next == 8'd0) ? LINK_UP : LINK_DOWN;
        end
        PT_PUBLISH: begin
          if (pub_ok && fixed_header_next[2:1] != 2'd0) begin
            pid = acc_id_next;
          end
          puback = pub_ok && fixed_header_next[2:1] == 2'd1;
        end
        PT_PUBACK: begin
          if (rl_ge2) begin
            pid   = acc_id_next;
            match = pending_ack_id != 16'd0 && acc_id_next == pending_ack_id;
          end
        end
        default: begin
          link_next = link_pre;
        end
      endcase
    end
  end

  // Result assembly
  always_comb begin
    res_next.event_res    = ev;
    res_next.data_byte    = data_b;
    res_next.section      = sec;
    res_next.packet_type  = fixed_header_next[7:4];
    res_next.header_flags = fixed_header_next[3:0];
    res_next.body_length  = rem_len_next;
    res_next.packet_done  = done;
    res_next.link_status  = link_next;
    res_next.publish_ok   = fin && fixed_header_next[7:4] == PT_PUBLISH && pub_ok;
    res_next.msg_id       = pid;
    res_next.send_puback  = puback;
    res_next.ack_matched  = match;
  end

  // Receiver state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      link_state   <= LINK_DOWN;
      phase        <= PH_IDLE;
      fixed_header <= '0;
      rem_len      <= '0;
      len_count    <= '0;
      body_pos     <= '0;
      elapsed      <= '0;
      topic_size   <= '0;
      acc_id       <= '0;
      ret_code     <= '0;
    end else if (accept) begin
      link_state   <= link_next;
      phase        <= phase_next;
      fixed_header <= fixed_header_next;
      rem_len      <= rem_len_next;
      len_count    <= len_count_next;
      body_pos     <= body_pos_next;
      elapsed      <= elapsed_next;
      topic_size   <= topic_size_next;
      acc_id       <= acc_id_next;
      ret_code     <= ret_code_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_len <= MAX_BODY_RST;
      timeout_ms   <= TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_BODY: max_body_len <= cfg_data[27:0];
        CFG_TIMEOUT:  timeout_ms   <= cfg_data[15:0];
        default:      timeout_ms   <= timeout_ms;
      endcase
    end
  end

  // Output register: load on accept, empty once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = res.packet_done;
  assign m_axis_tuser  = {res.section, res.event_res};
  assign m_axis_tdata  = {7'd0, res.ack_matched, res.send_puback, res.msg_id,
                          res.publish_ok, res.link_status, res.body_length,
                          res.header_flags, res.packet_type, res.data_byte};

  // A disconnected link never holds a packet in progress
  assert property (@(posedge clk) disable iff (rst)
    link_state == LINK_DOWN |-> phase == PH_IDLE)
    else $error("receiver active while link is down");

  // The length field never runs past four digits
  assert property (@(posedge clk) disable iff (rst)
    phase == PH_LENGTH |-> len_count <= 3'd4)
    else $error("length digit count overran");

  // A connect request always reports a connecting link
  assert property (@(posedge clk) disable iff (rst)
    (accept && mode == MODE_CONNECT) |=>
      (m_axis_tvalid && res.link_status == LINK_CONNECTING &&
       res.event_res == EV_CONNECT))
    else $error("connect item not reported");

  // Packet end only on length, body or discarded bytes
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |->
      (res.event_res == EV_LEN || res.event_res == EV_BODY ||
       res.event_res == EV_DISCARD))
    else $error("packet end on wrong event");

  // End-of-packet report only with packet end
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (res.publish_ok || res.send_puback || res.ack_matched)) |->
      m_axis_tlast)
    else $error("packet report without packet end");

endmodule

`default_nettype wire

/* verif/tb_mqtt_receive_deframer.sv */
module tb_mqtt_receive_deframer;
  timeunit 1ns;
  timeprecision 1ps;
  import mqtt_rd_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  // tdata: rx_byte [7:0], pending_ack_id [23:8]
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // tuser: mode [1:0]
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // tdata: data_byte, packet_type, header_flags, body_length, link_status,
  // publish_ok, msg_id, send_puback, ack_matched, zero fill
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // tuser: event_res [3:0], section [6:4]
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mqtt_receive_deframer dut (.*);

  // Tracked receiver state and limits
  logic [1:0]  trk_link       = LINK_DOWN;
  logic [1:0]  trk_phase      = PH_IDLE;
  logic [7:0]  trk_header     = '0;
  logic [27:0] trk_rem_len    = '0;
  logic [2:0]  trk_len_cnt    = '0;
  logic [27:0] trk_pos        = '0;
  logic [15:0] trk_ticks      = '0;
  logic [15:0] trk_topic_size = '0;
  logic [15:0] trk_id_acc     = '0;
  logic [7:0]  trk_ret_code   = '0;
  logic [27:0] trk_body_limit = MAX_BODY_RST;
  logic [15:0] trk_tick_limit = TIMEOUT_RST;

  res_t        predicted_results[$];
  logic [15:0] pending_id = '0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned error_count = 0;
  int unsigned tick_pct = 3;
  bit          sender_gaps = 1'b1;
  bit          receiver_stalls = 1'b1;

  initial forever #5 clk = ~clk;

  // End-of-packet report; CONNACK also decides the link
  function automatic res_t report_packet_end(res_t r, logic [15:0] pend);
    int unsigned need;
    logic [1:0]  qos;
    need = 2 + trk_topic_size;
    qos  = trk_header[2:1];
    case (trk_header[7:4])
      PT_CONNACK: begin
        trk_link = (trk_rem_len >= 2 && trk_ret_code == 8'd0) ? LINK_UP : LINK_DOWN;
      end
      PT_PUBLISH: begin
        r.publish_ok = (trk_rem_len >= 2) && (need <= trk_rem_len) &&
                       (qos == 2'd0 || need + 2 <= trk_rem_len);
        if (r.publish_ok && qos != 2'd0) r.msg_id = trk_id_acc;
        r.send_puback = r.publish_ok && qos == 2'd1;
      end
      PT_PUBACK: begin
        if (trk_rem_len >= 2) begin
          r.msg_id      = trk_id_acc;
          r.ack_matched = pend != 16'd0 && trk_id_acc == pend;
        end
      end
      default: ;
    endcase
    trk_phase = PH_IDLE;
    return r;
  endfunction

  // Expected result of one item; advances the tracked state
  function automatic res_t deframe_step(logic [1:0] kind, logic [7:0] rx, logic [15:0] pend);
    res_t        r;
    int unsigned pos, tpos;
    logic        kept;
    r   = '0;
    pos = trk_pos;
    if (kind == MODE_CONNECT) begin
      trk_link    = LINK_CONNECTING;
      trk_phase   = PH_IDLE;
      r.event_res = EV_CONNECT;
    end else if (trk_link == LINK_DOWN) begin
      r.event_res = EV_NONE;
    end else if (kind == MODE_CLOSED) begin
      trk_link    = LINK_DOWN;
      trk_phase   = PH_IDLE;
      r.event_res = EV_CLOSED;
    end else if (kind == MODE_TICK) begin
      if (trk_phase != PH_IDLE) begin
        if (trk_ticks != 16'hFFFF) trk_ticks++;
        if (trk_ticks >= trk_tick_limit) begin
          trk_link    = LINK_DOWN;
          trk_phase   = PH_IDLE;
          r.event_res = EV_TIMEOUT;
        end
      end
    end else if (trk_phase != PH_IDLE && trk_ticks >= trk_tick_limit) begin
      // limit already reached: the byte is lost
      trk_link    = LINK_DOWN;
      trk_phase   = PH_IDLE;
      r.event_res = EV_TIMEOUT;
    end else if (trk_phase == PH_IDLE) begin
      trk_header     = rx;
      trk_rem_len    = '0;
      trk_len_cnt    = '0;
      trk_pos        = '0;
      trk_ticks      = '0;
      trk_topic_size = '0;
      trk_id_acc     = '0;
      trk_ret_code   = '0;
      trk_phase      = PH_LENGTH;
      r.event_res    = EV_HEADER;
    end else if (trk_phase == PH_LENGTH) begin
      if (trk_len_cnt >= 3'd4) begin
        trk_link    = LINK_DOWN;
        trk_phase   = PH_IDLE;
        r.event_res = EV_BAD_LEN;
      end else begin
        trk_rem_len = trk_rem_len + (28'(rx[6:0]) << (7 * trk_len_cnt));
        trk_len_cnt++;
        r.event_res = EV_LEN;
        if (!rx[7]) begin
          trk_pos = '0;
          if (trk_rem_len == 28'd0) begin
            r.packet_done = 1'b1;
            r = report_packet_end(r, pend);
          end else if (trk_rem_len <= trk_body_limit) begin
            trk_phase = PH_BODY;
          end else begin
            trk_phase = PH_DISCARD;
          end
        end
      end
    end else begin
      r.data_byte = rx;
      kept = trk_phase == PH_BODY;
      if (kept) begin
        r.event_res = EV_BODY;
        tpos = pos - 2;
        if (trk_header[7:4] == PT_PUBLISH) begin
          if (pos < 2) begin
            trk_topic_size = {trk_topic_size[7:0], rx};
            r.section = SEC_TOPIC_LEN;
          end else if (tpos < trk_topic_size) begin
            r.section = (tpos < TOPIC_BUF - 1) ? SEC_TOPIC : SEC_TOPIC_DRP;
          end else if (trk_header[2:1] != 2'd0 && tpos - trk_topic_size < 2) begin
            trk_id_acc = {trk_id_acc[7:0], rx};
            r.section  = SEC_PKT_ID;
          end else begin
            r.section = SEC_PAYLOAD;
          end
        end else if (trk_header[7:4] == PT_PUBACK && pos < 2) begin
          trk_id_acc = {trk_id_acc[7:0], rx};
          r.section  = SEC_PKT_ID;
        end else begin
          if (trk_header[7:4] == PT_CONNACK && pos == 1) trk_ret_code = rx;
          r.section = SEC_OTHER;
        end
      end else begin
        r.event_res = EV_DISCARD;
      end
      trk_pos = trk_pos + 28'd1;
      if (trk_pos >= trk_rem_len) begin
        trk_phase = PH_IDLE;
        if (kept) r = report_packet_end(r, pend);
        r.packet_done = 1'b1;
      end
    end
    r.packet_type  = trk_header[7:4];
    r.header_flags = trk_header[3:0];
    r.body_length  = trk_rem_len;
    r.link_status  = trk_link;
    return r;
  endfunction

  task automatic flag_mismatch(string what, int unsigned idx, longint unsigned got_v,
                               longint unsigned want_v);
    error_count++;
    if (error_count <= 40)
      $display("result %0d: %s is %0h, expected %0h", idx, what, got_v, want_v);
  endtask

  // Drive one item; predict it once its transfer happens
  task automatic send_item(logic [1:0] kind, logic [7:0] rx);
    res_t step_result;
    while (sender_gaps && $urandom_range(0, 99) < 25) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {pending_id, rx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    step_result = deframe_step(kind, rx, pending_id);
    predicted_results.push_back(step_result);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (predicted_results.size() != 0);
  endtask

  // Header, remaining length digits for 'declared', then the given body bytes
  task automatic send_packet(logic [7:0] hdr, int unsigned declared, logic [7:0] body[$]);
    logic [7:0]  stream[$];
    int unsigned rest;
    rest = declared;
    stream.push_back(hdr);
    do begin
      stream.push_back({1'b1, 7'(rest % 128)});
      rest = rest / 128;
    end while (rest != 0);
    // sometimes a padded encoding with zero digits
    while (stream.size() < 5 && $urandom_range(0, 4) == 0) stream.push_back(8'h80);
    stream[stream.size()-1] = stream[stream.size()-1] & 8'h7F;
    stream = {stream, body};
    foreach (stream[i]) begin
      if (i != 0 && $urandom_range(0, 99) < tick_pct) send_item(MODE_TICK, 8'($urandom));
      send_item(MODE_BYTE, stream[i]);
    end
  endtask

  task automatic set_limits(logic [27:0] body_max, logic [15:0] tick_max);
    wait_drained();
    repeat (2) @(negedge clk);
    for (int i = 0; i < 2; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (i == 0) ? CFG_MAX_BODY : CFG_TIMEOUT;
      cfg_data  <= (i == 0) ? body_max : CFG_DATA_W'(tick_max);
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      if (i == 0) trk_body_limit = body_max;
      else trk_tick_limit = tick_max;
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // One well-formed packet with random content, sometimes cut short
  task automatic send_random_packet();
    logic [7:0]  body[$];
    logic [7:0]  hdr;
    logic [15:0] tlen, pid;
    int unsigned pick, n;
    pick = $urandom_range(0, 9);
    pid  = 16'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: pending_id = pid;
      4, 5:       pending_id = 16'd0;
      default:    pending_id = 16'($urandom);
    endcase
    if (pick < 5) begin
      hdr = {PT_PUBLISH, 4'($urandom)};
      case ($urandom_range(0, 5))
        0:       tlen = 16'($urandom_range(60, 70));
        1:       tlen = 16'($urandom);
        default: tlen = 16'($urandom_range(0, 8));
      endcase
      body.push_back(tlen[15:8]);
      body.push_back(tlen[7:0]);
      n = (tlen > 70) ? $urandom_range(0, 6) : tlen;
      repeat (n) body.push_back(8'($urandom));
      if (hdr[2:1] != 2'd0) begin
        body.push_back(pid[15:8]);
        body.push_back(pid[7:0]);
      end
      repeat ($urandom_range(0, 6)) body.push_back(8'($urandom));
    end else if (pick < 7) begin
      hdr = {PT_PUBACK, 4'($urandom)};
      body.push_back(pid[15:8]);
      body.push_back(pid[7:0]);
      repeat ($urandom_range(0, 1)) body.push_back(8'($urandom));
    end else if (pick < 8) begin
      hdr = {PT_CONNACK, 4'($urandom)};
      body.push_back(8'($urandom));
      body.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd0);
    end else begin
      hdr = 8'($urandom);
      repeat ($urandom_range(0, 6)) body.push_back(8'($urandom));
    end
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 3)) if (body.size() != 0) void'(body.pop_back());
    send_packet(hdr, body.size(), body);
  endtask

  // Mostly complete packets; the rest cut packets, bad lengths and noise
  task automatic run_traffic(int unsigned n_items);
    logic [7:0]  body[$];
    int unsigned stop_at, pick, n, declared;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if (trk_link == LINK_DOWN && $urandom_range(0, 9) != 0)
        send_item(MODE_CONNECT, 8'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        send_random_packet();
      end else if (pick < 82) begin
        // packet cut short, then a restart or a peer close
        body.delete();
        n = $urandom_range(0, 5);
        repeat (n) body.push_back(8'($urandom));
        declared = $urandom_range(0, 1) ? n + $urandom_range(1, 4)
                                        : $urandom_range(n + 1, 28'hFFFFFFF);
        send_packet(8'($urandom), declared, body);
        send_item($urandom_range(0, 1) ? MODE_CONNECT : MODE_CLOSED, 8'($urandom));
      end else if (pick < 86) begin
        // five length bytes
        send_item(MODE_BYTE, 8'($urandom));
        repeat (4) send_item(MODE_BYTE, 8'($urandom) | 8'h80);
        send_item(MODE_BYTE, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          pending_id = 16'($urandom);
          send_item(2'($urandom), 8'($urandom));
        end
      end
      if ($urandom_range(0, 29) == 0) wait_drained();
    end
  endtask

  task automatic test_directed();
    logic [7:0] no_body[$];
    pending_id = 16'h1234;
    tick_pct   = 0;
    // link down: byte, tick and close are ignored
    send_item(MODE_BYTE, 8'hFF);
    send_item(MODE_TICK, 8'h00);
    send_item(MODE_CLOSED, 8'h00);
    send_item(MODE_CONNECT, 8'h00);
    send_item(MODE_TICK, 8'hFF);
    // accepted CONNACK brings the link up
    send_packet({PT_CONNACK, 4'h0}, 2, '{8'h00, 8'h00});
    // QoS 1 PUBLISH asks for a PUBACK
    send_packet({PT_PUBLISH, 4'h2}, 7, '{8'h00, 8'h01, 8'h61, 8'h12, 8'h34, 8'hFF, 8'h00});
    // PUBACK for the pending id
    send_packet({PT_PUBACK, 4'h0}, 2, '{8'h12, 8'h34});
    // empty body completes on its length byte
    send_packet(8'hD0, 0, no_body);
    // fifth length byte drops the link
    send_item(MODE_BYTE, {PT_PUBLISH, 4'hF});
    repeat (4) send_item(MODE_BYTE, 8'hFF);
    send_item(MODE_BYTE, 8'h00);
    tick_pct = 3;
  endtask

  task automatic test_random_traffic();
    run_traffic(250);
  endtask

  task automatic test_back_to_back();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    run_traffic(120);
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  task automatic test_limit_settings();
    // everything discarded, first tick mid-packet times out
    set_limits(28'd0, 16'd1);
    tick_pct = 5;
    run_traffic(80);
    set_limits(28'hFFFFFFF, 16'hFFFF);
    run_traffic(80);
    set_limits(28'd12, 16'd4);
    tick_pct = 25;
    run_traffic(120);
    // limit lowered mid-packet: the next byte times out
    tick_pct = 0;
    send_item(MODE_CONNECT, 8'h00);
    send_item(MODE_BYTE, {PT_PUBLISH, 4'h0});
    send_item(MODE_BYTE, 8'h05);
    repeat (2) send_item(MODE_TICK, 8'h00);
    set_limits(28'd12, 16'd1);
    send_item(MODE_BYTE, 8'hA5);
    set_limits(MAX_BODY_RST, TIMEOUT_RST);
    tick_pct = 3;
    run_traffic(40);
  endtask

  // Result side stalls
  always @(negedge clk)
    m_axis_tready <= !receiver_stalls || $urandom_range(0, 99) >= 25;

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    res_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.event_res    = m_axis_tuser[3:0];
      got.section      = m_axis_tuser[6:4];
      got.data_byte    = m_axis_tdata[7:0];
      got.packet_type  = m_axis_tdata[11:8];
      got.header_flags = m_axis_tdata[15:12];
      got.body_length  = m_axis_tdata[43:16];
      got.link_status  = m_axis_tdata[45:44];
      got.publish_ok   = m_axis_tdata[46];
      got.msg_id       = m_axis_tdata[62:47];
      got.send_puback  = m_axis_tdata[63];
      got.ack_matched  = m_axis_tdata[64];
      got.packet_done  = m_axis_tlast;
      if (predicted_results.size() == 0) begin
        flag_mismatch("unrequested result", results_seen, got.event_res, 0);
      end else begin
        want = predicted_results.pop_front();
        if (got.event_res !== want.event_res)
          flag_mismatch("event_res", results_seen, got.event_res, want.event_res);
        if (got.data_byte !== want.data_byte)
          flag_mismatch("data_byte", results_seen, got.data_byte, want.data_byte);
        if (got.section !== want.section)
          flag_mismatch("section", results_seen, got.section, want.section);
        if (got.packet_type !== want.packet_type)
          flag_mismatch("packet_type", results_seen, got.packet_type, want.packet_type);
        if (got.header_flags !== want.header_flags)
          flag_mismatch("header_flags", results_seen, got.header_flags, want.header_flags);
        if (got.body_length !== want.body_length)
          flag_mismatch("body_length", results_seen, got.body_length, want.body_length);
        if (got.packet_done !== want.packet_done)
          flag_mismatch("packet_done", results_seen, got.packet_done, want.packet_done);
        if (got.link_status !== want.link_status)
          flag_mismatch("link_status", results_seen, got.link_status, want.link_status);
        if (got.publish_ok !== want.publish_ok)
          flag_mismatch("publish_ok", results_seen, got.publish_ok, want.publish_ok);
        if (got.msg_id !== want.msg_id)
          flag_mismatch("msg_id", results_seen, got.msg_id, want.msg_id);
        if (got.send_puback !== want.send_puback)
          flag_mismatch("send_puback", results_seen, got.send_puback, want.send_puback);
        if (got.ack_matched !== want.ack_matched)
          flag_mismatch("ack_matched", results_seen, got.ack_matched, want.ack_matched);
      end
      results_seen++;
    end
  end

  // Watchdog: too long without any transfer
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random_traffic();
    test_back_to_back();
    test_limit_settings();
    wait_drained();
    repeat (5) @(posedge clk);
    if (error_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

/* files.f */
hdl/mqtt_rd_pkg.sv
hdl/mqtt_receive_deframer.sv
verif/tb_mqtt_receive_deframer.sv
